// ----- hdl/ngla_pkg.sv -----
`timescale 1ns / 1ps

package ngla_pkg;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
	localparam logic [32:0] Q32_ONE     = 33'h1_0000_0000;
	localparam logic [22:0] KS_Q32      = 23'd8297244;
	localparam logic [24:0] E2_Q32      = 25'd28752143;
	localparam logic [31:0] GE_Q28      = 32'd2625386091;
	localparam logic [25:0] QR_Q48      = 26'd44131222;
	localparam logic [30:0] C1_Q30      = 31'd1081046056;
	localparam logic [27:0] OUT_MAX     = 28'hFFF_FFFF;

	localparam int NSIN = 6;
	localparam int NRT  = 16;
	localparam int NDV  = 16;

	// horner divisors 2n(2n+1), n = 6 down to 1, with floor reciprocals
	localparam logic [7:0]  SIN_DIV [0:NSIN-1] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [31:0] SIN_RCP [0:NSIN-1] = '{32'd3524075730, 32'd2498890063,
		32'd3817748707, 32'd3272356035, 32'd3435973836, 32'd2863311530};
	localparam int          SIN_SH  [0:NSIN-1] = '{39, 38, 38, 37, 36, 34};

	typedef struct packed {
		logic [30:0] x;
		logic [31:0] x2;
		logic [32:0] k;
		logic [30:0] t;
		logic [31:0] v;
		logic [31:0] qa;
	} sin_t;

	typedef struct packed {
		logic [31:0] p;
		logic [32:0] k;
		logic [62:0] rem;
		logic [62:0] res;
	} rt_t;

	typedef struct packed {
		logic [31:0] r;
		logic [32:0] k;
		logic        p0;
		logic [31:0] rem;
		logic [31:0] quo;
	} dv_t;

	function automatic sin_t sin_mul(sin_t a);
		sin_t o;
		logic [62:0] prod;
		o = a;
		prod = 63'(a.x2) * 63'(a.t);
		o.v = prod[61:30];
		return o;
	endfunction

	function automatic sin_t sin_rcp(sin_t a, int it);
		sin_t o;
		logic [63:0] prod;
		o = a;
		prod = 64'(a.v) * 64'(SIN_RCP[it]);
		o.qa = 32'(prod >> SIN_SH[it]);
		return o;
	endfunction

	function automatic sin_t sin_fix(sin_t a, int it);
		sin_t o;
		logic [39:0] qd;
		logic [31:0] rem;
		logic [31:0] qc;
		o = a;
		qd = 40'(a.qa) * 40'(SIN_DIV[it]);
		rem = a.v - qd[31:0];
		qc = a.qa + ((rem >= 32'(SIN_DIV[it])) ? 32'd1 : 32'd0);
		o.t = 31'(Q30_ONE - qc);
		return o;
	endfunction

	function automatic rt_t rt_two(rt_t a, int st);
		rt_t o;
		logic [62:0] bt;
		logic [62:0] tr;
		o = a;
		for (int n = 0; n < 2; n++) begin
			bt = 63'(1) << (62 - 2 * (2 * st + n));
			tr = o.res + bt;
			if (o.rem >= tr) begin
				o.rem = o.rem - tr;
				o.res = (o.res >> 1) + bt;
			end else begin
				o.res = o.res >> 1;
			end
		end
		return o;
	endfunction

	function automatic dv_t dv_two(dv_t a, int st);
		dv_t o;
		logic [32:0] w;
		o = a;
		for (int n = 0; n < 2; n++) begin
			w = {o.rem, ((2 * st + n) == 0) ? o.p0 : 1'b0};
			if (w >= {1'b0, o.r}) begin
				o.rem = 32'(w - {1'b0, o.r});
				o.quo = {o.quo[30:0], 1'b1};
			end else begin
				o.rem = w[31:0];
				o.quo = {o.quo[30:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage

// ----- hdl/normal_gravity_lat_alt_unit.sv -----
`timescale 1ns / 1ps
// normal gravity magnitude at a geodetic latitude and height (wgs-84)
// request channel: req_valid / req_ready carry latitude (2^-30 rad, signed)
//   and altitude (2^-8 m, signed); a transaction completes when both are high
// response channel: rsp_valid / rsp_ready carry gravity_down (2^-24 m/s^2)
// every request gives exactly one response, in order
// the pipeline depth is set by the sine horner steps (3 stages each), the
//   2-bit-per-stage square root and the 2-bit-per-stage restoring divider
// throughput: one transaction per cycle while rsp_ready does not stall the output
// each stage moves when it is empty or the next stage moves, so a stalled
//   response holds in the output register while upstream bubbles still fill;
//   nothing is dropped or repeated
// reset clears all stage valid bits; no response is pending after reset
module normal_gravity_lat_alt_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic signed [31:0] latitude,
	input  logic signed [25:0] altitude,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic        [27:0] gravity_down
);
	import ngla_pkg::*;

	localparam int P_SIN = 3;
	localparam int P_S   = P_SIN + 3 * NSIN + 1;
	localparam int P_S2  = P_S + 1;
	localparam int P_ND  = P_S2 + 1;
	localparam int P_RT  = P_ND + 1;
	localparam int P_DV  = P_RT + NRT + 1;
	localparam int P_OUT = P_DV + NDV + 1;
	localparam int NS    = P_OUT + 1;

	logic [NS-1:0] vld;
	logic [NS-1:0] en;
	logic [NS-1:0] vin;
	logic [NS-1:0] ld;

	assign en[NS-1] = !vld[NS-1] || rsp_ready;
	for (genvar gi = 0; gi < NS - 1; gi++) begin : g_en
		assign en[gi] = !vld[gi] || en[gi+1];
	end
	assign vin = {vld[NS-2:0], req_valid};
	assign ld  = en & vin;
	assign req_ready = en[0];
	assign rsp_valid = vld[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= (vld & ~en) | (vin & en);
		end
	end

	// front: magnitudes, x^2, height factor
	logic [31:0] lat_mag;
	logic [25:0] alt_mag;
	assign lat_mag = latitude[31] ? (~latitude + 32'd1) : latitude;
	assign alt_mag = altitude[25] ? (~altitude + 26'd1) : altitude;

	logic [30:0] x_s1, x_s2, x_s3;
	logic        hneg_s1, hneg_s2, hneg_s3;
	logic [25:0] hmag_s1;
	logic [31:0] x2_s2, x2_s3;
	logic [27:0] hq_s2;
	logic [28:0] lin_s3;
	logic [23:0] sq_s3;

	logic [61:0] xx_prod;
	logic [51:0] q_prod;
	logic [58:0] lin_prod;
	logic [55:0] sq_prod;
	assign xx_prod  = 62'(x_s1) * 62'(x_s1);
	assign q_prod   = 52'(hmag_s1) * 52'(QR_Q48);
	assign lin_prod = 59'(hq_s2) * 59'(C1_Q30);
	assign sq_prod  = 56'(hq_s2) * 56'(hq_s2);

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			x_s1    <= (lat_mag > 32'(HALF_PI_Q30)) ? HALF_PI_Q30 : lat_mag[30:0];
			hneg_s1 <= altitude[25];
			hmag_s1 <= alt_mag;
		end
		if (ld[1]) begin
			x_s2    <= x_s1;
			x2_s2   <= xx_prod[61:30];
			hneg_s2 <= hneg_s1;
			hq_s2   <= q_prod[51:24];
		end
		if (ld[2]) begin
			x_s3    <= x_s2;
			x2_s3   <= x2_s2;
			hneg_s3 <= hneg_s2;
			lin_s3  <= lin_prod[57:29];
			sq_s3   <= sq_prod[55:32];
		end
	end

	// sine: horner steps, each multiply / reciprocal / correct
	sin_t sin_s [0:3*NSIN];
	logic [32:0] quad;
	assign quad = 33'(sq_s3) + 33'({sq_s3, 1'b0});

	always_ff @(posedge clk) begin
		if (ld[P_SIN]) begin
			sin_s[0].x  <= x_s3;
			sin_s[0].x2 <= x2_s3;
			sin_s[0].k  <= hneg_s3 ? (Q32_ONE + 33'(lin_s3) + quad)
			                       : (Q32_ONE - 33'(lin_s3) + quad);
			sin_s[0].t  <= Q30_ONE[30:0];
			sin_s[0].v  <= '0;
			sin_s[0].qa <= '0;
		end
	end

	for (genvar gj = 1; gj <= 3 * NSIN; gj++) begin : g_sin
		localparam int IT = (gj - 1) / 3;
		localparam int PH = (gj - 1) % 3;
		always_ff @(posedge clk) begin
			if (ld[P_SIN+gj]) begin
				if (PH == 0) begin
					sin_s[gj] <= sin_mul(sin_s[gj-1]);
				end else if (PH == 1) begin
					sin_s[gj] <= sin_rcp(sin_s[gj-1], IT);
				end else begin
					sin_s[gj] <= sin_fix(sin_s[gj-1], IT);
				end
			end
		end
	end

	// sine, its square, somigliana numerator and denominator
	logic [30:0] s_s23;
	logic [32:0] k_s23, k_s24, k_s25;
	logic [30:0] s2_s24;
	logic [32:0] num_s25, den_s25;

	logic [61:0] s_prod;
	logic [31:0] s_full;
	logic [61:0] s2_prod;
	logic [53:0] ks_prod;
	logic [55:0] e2_prod;
	assign s_prod  = 62'(sin_s[3*NSIN].x) * 62'(sin_s[3*NSIN].t);
	assign s_full  = s_prod[61:30];
	assign s2_prod = 62'(s_s23) * 62'(s_s23);
	assign ks_prod = 54'(KS_Q32) * 54'(s2_s24);
	assign e2_prod = 56'(E2_Q32) * 56'(s2_s24);

	always_ff @(posedge clk) begin
		if (ld[P_S]) begin
			s_s23 <= (s_full > Q30_ONE) ? Q30_ONE[30:0] : s_full[30:0];
			k_s23 <= sin_s[3*NSIN].k;
		end
		if (ld[P_S2]) begin
			s2_s24 <= s2_prod[60:30];
			k_s24  <= k_s23;
		end
		if (ld[P_ND]) begin
			num_s25 <= Q32_ONE + 33'(ks_prod[53:30]);
			den_s25 <= Q32_ONE - 33'(e2_prod[55:30]);
			k_s25   <= k_s24;
		end
	end

	// square root of the denominator, two result bits per stage
	rt_t rt_s [0:NRT];
	logic [64:0] p_prod;
	assign p_prod = 65'(GE_Q28) * 65'(num_s25);

	always_ff @(posedge clk) begin
		if (ld[P_RT]) begin
			rt_s[0].p   <= p_prod[63:32];
			rt_s[0].k   <= k_s25;
			rt_s[0].rem <= {den_s25[32:0], 30'd0};
			rt_s[0].res <= '0;
		end
	end

	for (genvar gr = 1; gr <= NRT; gr++) begin : g_rt
		always_ff @(posedge clk) begin
			if (ld[P_RT+gr]) begin
				rt_s[gr] <= rt_two(rt_s[gr-1], gr - 1);
			end
		end
	end

	// restoring divide (p << 31) / r, two quotient bits per stage
	dv_t dv_s [0:NDV];

	always_ff @(posedge clk) begin
		if (ld[P_DV]) begin
			dv_s[0].r   <= (rt_s[NRT].res == '0) ? 32'd1 : rt_s[NRT].res[31:0];
			dv_s[0].k   <= rt_s[NRT].k;
			dv_s[0].p0  <= rt_s[NRT].p[0];
			dv_s[0].rem <= {1'b0, rt_s[NRT].p[31:1]};
			dv_s[0].quo <= '0;
		end
	end

	for (genvar gd = 1; gd <= NDV; gd++) begin : g_dv
		always_ff @(posedge clk) begin
			if (ld[P_DV+gd]) begin
				dv_s[gd] <= dv_two(dv_s[gd-1], gd - 1);
			end
		end
	end

	// height scaling and output register
	logic [27:0] g_s60;
	logic [64:0] g_prod;
	assign g_prod = 65'(dv_s[NDV].quo) * 65'(dv_s[NDV].k);

	always_ff @(posedge clk) begin
		if (ld[P_OUT]) begin
			g_s60 <= (g_prod[64:36] > 29'(OUT_MAX)) ? OUT_MAX : g_prod[63:36];
		end
	end

	assign gravity_down = g_s60;

	a_sin_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vld[P_SIN+3*NSIN] |-> sin_s[3*NSIN].t <= Q30_ONE[30:0])
		else $error("horner term above one");

	a_root_fit: assert property (@(posedge clk) disable iff (!arst_n)
		vld[P_DV-1] |-> rt_s[NRT].res[62:32] == '0)
		else $error("root wider than 32 bits");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld[P_OUT-1] |-> dv_s[NDV].rem < dv_s[NDV].r)
		else $error("divider remainder not below divisor");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld[P_RT] && !en[P_RT] |=> vld[P_RT] && $stable(rt_s[0]))
		else $error("stalled root stage lost its transaction");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import ngla_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic signed [31:0] latitude;
	logic signed [25:0] altitude;
	logic               rsp_valid;
	logic               rsp_ready;
	logic        [27:0] gravity_down;

	logic [27:0] gravity_queue [$];
	int          error_count;
	bit          quiet;
	int          ready_left;
	bit          ready_run;

	normal_gravity_lat_alt_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.latitude     (latitude),
		.altitude     (altitude),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.gravity_down (gravity_down)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bt;
		res = 0;
		rem = v;
		bt = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] sine_of(logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] s;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int n = 6; n >= 1; n--) begin
			d = 64'((2 * n) * (2 * n + 1));
			t = (64'd1 << 30) - (((x2 * t) >> 30) / d);
		end
		s = (x * t) >> 30;
		if (s > (64'd1 << 30))
			s = 64'd1 << 30;
		return s;
	endfunction

	function automatic logic [27:0] gravity_for(logic [31:0] lat, logic [25:0] alt);
		logic [63:0] x, s, s2, num, den, r, p, g0;
		logic [63:0] hmag, hq, lin, quad, k, g;
		bit          hneg;
		x = lat[31] ? (64'h1_0000_0000 - 64'(lat)) : 64'(lat);
		if (x > 64'(HALF_PI_Q30))
			x = 64'(HALF_PI_Q30);
		s = sine_of(x);
		s2 = (s * s) >> 30;
		num = (64'd1 << 32) + ((64'(KS_Q32) * s2) >> 30);
		den = (64'd1 << 32) - ((64'(E2_Q32) * s2) >> 30);
		r = floor_root(den << 30);
		if (r == 0)
			r = 1;
		p = (64'(GE_Q28) * num) >> 32;
		g0 = (p << 31) / r;
		hneg = alt[25];
		hmag = hneg ? (64'h400_0000 - 64'(alt)) : 64'(alt);
		hq = (hmag * 64'(QR_Q48)) >> 24;
		lin = (hq * 64'(C1_Q30)) >> 29;
		quad = 3 * ((hq * hq) >> 32);
		if (hneg)
			k = (64'd1 << 32) + lin + quad;
		else
			k = (64'd1 << 32) - lin + quad;
		g = (g0 * k) >> 36;
		if (g > 64'(OUT_MAX))
			g = 64'(OUT_MAX);
		return g[27:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// entered and left at a rising edge
	task automatic send_position(logic [31:0] lat, logic [25:0] alt);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		latitude  <= lat;
		altitude  <= alt;
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		gravity_queue.push_back(gravity_for(lat, alt));
	endtask

	task automatic test_latitude_extremes();
		logic [31:0] lats [10] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1686629713,
			-32'd1686629713, 32'd1686629714, -32'd1686629714, 32'h7FFF_FFFF,
			32'h8000_0000, 32'd843314856};
		foreach (lats[i])
			send_position(lats[i], 26'd0);
	endtask

	task automatic test_altitude_extremes();
		logic [25:0] alts [9] = '{-26'd256000, 26'd25600000, 26'd1, 26'h3FF_FFFF,
			26'h1FF_FFFF, 26'h200_0000, 26'd256, -26'd256, 26'd0};
		foreach (alts[i]) begin
			send_position(32'd1686629713, alts[i]);
			if (i < 3)
				send_position(32'h8000_0000, alts[i]);
		end
	endtask

	task automatic test_random_positions(int count);
		logic [31:0] lat;
		logic [25:0] alt;
		for (int i = 0; i < count; i++) begin
			if (i == count - 60)
				quiet = 1'b1;
			if ($urandom_range(0, 3) == 0)
				lat = $urandom;
			else
				lat = $urandom_range(0, 32'd3373259426) - 32'd1686629713;
			if ($urandom_range(0, 3) == 0)
				alt = 26'($urandom);
			else
				alt = 26'($signed($urandom_range(0, 25856000)) - 256000);
			send_position(lat, alt);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			ready_left <= 0;
			ready_run  <= 1'b0;
		end else if (quiet) begin
			rsp_ready <= 1'b1;
		end else if (ready_left == 0) begin
			ready_run  <= !ready_run;
			rsp_ready  <= !ready_run;
			ready_left <= ready_run ? $urandom_range(0, 14) : $urandom_range(1, 30);
		end else begin
			ready_left <= ready_left - 1;
		end
	end

	// a transaction seen at the falling edge completes at the next rising edge
	always @(negedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (gravity_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected gravity_down %0d", gravity_down));
			end else begin
				logic [27:0] want;
				want = gravity_queue.pop_front();
				if (gravity_down !== want)
					report_mismatch($sformatf("gravity_down %0d, expected %0d",
						gravity_down, want));
			end
		end
	end

	initial begin
		error_count = 0;
		quiet       = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		latitude    = '0;
		altitude    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_latitude_extremes();
		test_altitude_extremes();
		test_random_positions(500);
		req_valid <= 1'b0;
		while (gravity_queue.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
